### rtl/heart_rate_averager_top_macros.svh
// Assertion helpers for the heart rate averager.
`ifndef HEART_RATE_AVERAGER_TOP_MACROS_SVH
`define HEART_RATE_AVERAGER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HRA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hra assertion failed");
// next-cycle implication
`define HRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hra assertion failed");
`else
`define HRA_ASSERT_NOW(label, ante, cons)
`define HRA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/hra_pkg.sv
`timescale 1ns / 1ps
package hra_pkg;

    localparam int RATE_COUNT = 4;
    localparam int IDX_W      = (RATE_COUNT > 1) ? $clog2(RATE_COUNT) : 1;
    localparam int SUM_W      = 8 + IDX_W;

    localparam int QUO_W = 16;
    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [QUO_W-1:0] MS_PER_MINUTE = 16'd60000;

    localparam int CFG_W  = 18;
    localparam int CIDX_W = 2;

    localparam logic [CIDX_W-1:0] CFG_FINGER_THR = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MIN_RATE   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_RATE   = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_ELEV_RATE  = 2'd3;

    localparam logic [17:0] FINGER_THR_RST = 18'd50000;
    localparam logic [7:0]  MIN_RATE_RST   = 8'd20;
    localparam logic [7:0]  MAX_RATE_RST   = 8'd255;
    localparam logic [7:0]  ELEV_RATE_RST  = 8'd100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic clear;
        logic write;
    } ring_ctl_t;

endpackage

### rtl/heart_rate_averager_top.sv
`timescale 1ns / 1ps
// channel | handshake   | fields
// --------+-------------+--------------------------------------------------------------------
// in      | valid/ready | ir_level beat time_ms
// out     | valid/ready | finger_present beat_accepted instant_rate average_rate rate_elevated
// cfg     | cfg_wr_en   | cfg_index cfg_data
//
// A beat with a finger present: the sequencer runs the divider (16 divider steps), then one step to see done
// and one finish step that registers the result; the next item is accepted once the sequencer is idle again.
// Other items go straight from accept to the finish step.
// in_ready is high only while the sequencer is idle.
// The result register lets the next item enter while a result waits; the
// sequencer stalls in its finish step until that register is free.
// Reset restores the config, sequencer, last beat, instant rate and out_valid and empties the rate ring.
`include "heart_rate_averager_top_macros.svh"
module heart_rate_averager_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [17:0]                   ir_level,
    input  logic                          beat,
    input  logic [31:0]                   time_ms,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          finger_present,
    output logic                          beat_accepted,
    output logic [15:0]                   instant_rate,
    output logic [7:0]                    average_rate,
    output logic                          rate_elevated,
    input  logic                          cfg_wr_en,
    input  logic [hra_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [hra_pkg::CFG_W-1:0]     cfg_data
);

    hra_pkg::state_t      state_reg, state_next;
    hra_pkg::div_status_t div_status;
    hra_pkg::ring_ctl_t   ring_ctl;

    logic [17:0] finger_thr_reg;
    logic [7:0]  min_rate_reg, max_rate_reg, elev_rate_reg;

    logic        finger_reg, beat_reg, zero_reg;
    logic [31:0] time_reg, last_beat_reg;
    logic [15:0] instant_reg;

    logic        out_valid_reg;
    logic        out_finger_reg, out_accept_reg, out_elev_reg;
    logic [15:0] out_instant_reg;
    logic [7:0]  out_avg_reg;

    logic        in_fire, finish, div_start, rem_nonzero;
    logic [31:0] delta;
    logic [15:0] quotient, rate_q;
    logic        accept;
    logic [7:0]  avg_now, avg_after, avg_sel;

    assign in_ready = (state_reg == hra_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign delta    = time_ms - last_beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finger_thr_reg <= hra_pkg::FINGER_THR_RST;
            min_rate_reg   <= hra_pkg::MIN_RATE_RST;
            max_rate_reg   <= hra_pkg::MAX_RATE_RST;
            elev_rate_reg  <= hra_pkg::ELEV_RATE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hra_pkg::CFG_FINGER_THR: finger_thr_reg <= cfg_data;
                hra_pkg::CFG_MIN_RATE:   min_rate_reg   <= cfg_data[7:0];
                hra_pkg::CFG_MAX_RATE:   max_rate_reg   <= cfg_data[7:0];
                hra_pkg::CFG_ELEV_RATE:  elev_rate_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            hra_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ((ir_level >= finger_thr_reg) && beat)
                    begin
                        div_start  = 1'b1;
                        state_next = hra_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = hra_pkg::ST_DONE;
                    end
                end
            end
            hra_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = hra_pkg::ST_DONE;
                end
            end
            hra_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    finish     = 1'b1;
                    state_next = hra_pkg::ST_IDLE;
                end
            end
            default: state_next = hra_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hra_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    hra_div u_div
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .divisor     (delta),
        .status      (div_status),
        .quotient    (quotient),
        .rem_nonzero (rem_nonzero)
    );

    // min*d < 60000 iff min < q, or min == q with a remainder; max*d > 60000 iff max > q
    always_comb
    begin
        rate_q = zero_reg ? hra_pkg::MS_PER_MINUTE : quotient;
        accept = finger_reg && beat_reg && !zero_reg
                 && ((16'(min_rate_reg) < quotient)
                     || ((16'(min_rate_reg) == quotient) && rem_nonzero))
                 && (16'(max_rate_reg) > quotient);
        ring_ctl.clear = finish && !finger_reg;
        ring_ctl.write = finish && accept;
        avg_sel = !finger_reg ? 8'd0 : (accept ? avg_after : avg_now);
    end

    hra_ring u_ring
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ring_ctl),
        .rate            (rate_q[7:0]),
        .avg             (avg_now),
        .avg_after_write (avg_after)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            finger_reg <= (ir_level >= finger_thr_reg);
            beat_reg   <= beat;
            zero_reg   <= (delta == '0);
            time_reg   <= time_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_beat_reg <= '0;
            instant_reg   <= '0;
        end
        else if (finish)
        begin
            if (!finger_reg)
            begin
                last_beat_reg <= '0;
                instant_reg   <= '0;
            end
            else if (beat_reg)
            begin
                last_beat_reg <= time_reg;
                instant_reg   <= rate_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_finger_reg  <= finger_reg;
            out_accept_reg  <= accept;
            out_instant_reg <= !finger_reg ? 16'd0 : (beat_reg ? rate_q : instant_reg);
            out_avg_reg     <= avg_sel;
            out_elev_reg    <= finger_reg && (avg_sel >= elev_rate_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign finger_present = out_finger_reg;
    assign beat_accepted  = out_accept_reg;
    assign instant_rate   = out_instant_reg;
    assign average_rate   = out_avg_reg;
    assign rate_elevated  = out_elev_reg;

    `HRA_ASSERT_NOW(a_accept_needs_finger, out_valid && beat_accepted, finger_present)
    `HRA_ASSERT_NOW(a_no_finger_clear, out_valid && !finger_present, (instant_rate == 16'd0) && (average_rate == 8'd0) && !rate_elevated)
    `HRA_ASSERT_NEXT(a_div_start_busy, div_start, div_status.busy && (state_reg == hra_pkg::ST_DIV))
    `HRA_ASSERT_NOW(a_accept_rate_small, out_valid && beat_accepted, instant_rate < 16'd255)

endmodule

### rtl/hra_div.sv
`timescale 1ns / 1ps
// Restoring divider: 60000 / divisor, one quotient bit per cycle.
module hra_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [31:0]                 divisor,
    output hra_pkg::div_status_t        status,
    output logic [hra_pkg::QUO_W-1:0]   quotient,
    output logic                        rem_nonzero
);

    logic [31:0]                 divisor_reg;
    logic [hra_pkg::QUO_W-1:0]   quo_reg, quo_next;
    logic [hra_pkg::QUO_W-1:0]   rem_reg, rem_next;
    logic [hra_pkg::CNT_W-1:0]   cnt_reg;
    logic                        busy_reg, done_reg;
    logic [hra_pkg::QUO_W:0]     trial;
    logic                        fits;

    // quo_reg holds the remaining dividend bits on the left, quotient bits enter on the right
    always_comb
    begin
        trial    = {rem_reg, quo_reg[hra_pkg::QUO_W-1]};
        fits     = {15'd0, trial} >= divisor_reg;
        rem_next = fits ? 16'(trial - divisor_reg[hra_pkg::QUO_W:0]) : trial[hra_pkg::QUO_W-1:0];
        quo_next = {quo_reg[hra_pkg::QUO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= hra_pkg::CNT_W'(hra_pkg::QUO_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            quo_reg     <= hra_pkg::MS_PER_MINUTE;
            rem_reg     <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign rem_nonzero = (rem_reg != '0);

endmodule

### rtl/hra_ring.sv
`timescale 1ns / 1ps
// Rate ring with a running sum; average = sum / RATE_COUNT.
module hra_ring
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hra_pkg::ring_ctl_t   ctl,
    input  logic [7:0]           rate,
    output logic [7:0]           avg,
    output logic [7:0]           avg_after_write
);

    logic [7:0]                  ring_reg [hra_pkg::RATE_COUNT];
    logic [hra_pkg::IDX_W-1:0]   idx_reg;
    logic [hra_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [7:0]                  avg_reg;
    logic [hra_pkg::SUM_W-1:0]   avg_wide;

    always_comb
    begin
        sum_next        = sum_reg - hra_pkg::SUM_W'(ring_reg[idx_reg])
                          + hra_pkg::SUM_W'(rate);
        avg_wide        = sum_next / hra_pkg::SUM_W'(hra_pkg::RATE_COUNT);
        avg_after_write = avg_wide[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hra_pkg::RATE_COUNT; i++)
            begin
                ring_reg[i] <= '0;
            end
            idx_reg <= '0;
            sum_reg <= '0;
            avg_reg <= '0;
        end
        else if (ctl.clear)
        begin
            for (int i = 0; i < hra_pkg::RATE_COUNT; i++)
            begin
                ring_reg[i] <= '0;
            end
            idx_reg <= '0;
            sum_reg <= '0;
            avg_reg <= '0;
        end
        else if (ctl.write)
        begin
            ring_reg[idx_reg] <= rate;
            sum_reg           <= sum_next;
            avg_reg           <= avg_after_write;
            if (idx_reg == hra_pkg::IDX_W'(hra_pkg::RATE_COUNT - 1))
            begin
                idx_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign avg = avg_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 30;
    localparam logic [17:0] IR_MAX = 18'h3FFFF;

    typedef struct packed {
        logic [17:0] ir;
        logic        pulse;
        logic [31:0] stamp;
        logic        drain;
    } sample_t;

    typedef struct packed {
        logic        finger;
        logic        accepted;
        logic [15:0] inst;
        logic [7:0]  avg;
        logic        elev;
    } rate_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [17:0]                  ir_level = '0;
    logic                         beat = 1'b0;
    logic [31:0]                  time_ms = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         finger_present;
    logic                         beat_accepted;
    logic [15:0]                  instant_rate;
    logic [7:0]                   average_rate;
    logic                         rate_elevated;
    logic                         cfg_wr_en = 1'b0;
    logic [hra_pkg::CIDX_W-1:0]   cfg_index = '0;
    logic [hra_pkg::CFG_W-1:0]    cfg_data = '0;

    heart_rate_averager_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .ir_level       (ir_level),
        .beat           (beat),
        .time_ms        (time_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .finger_present (finger_present),
        .beat_accepted  (beat_accepted),
        .instant_rate   (instant_rate),
        .average_rate   (average_rate),
        .rate_elevated  (rate_elevated),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // predictor copy of registers and rate state
    logic [17:0]                 thr_q;
    logic [7:0]                  min_q;
    logic [7:0]                  max_q;
    logic [7:0]                  elev_q;
    logic [7:0]                  ring_q [hra_pkg::RATE_COUNT];
    logic [hra_pkg::IDX_W-1:0]   wr_idx_q;
    logic [31:0]                 last_beat_q;
    logic [7:0]                  avg_q;
    logic [15:0]                 inst_q;

    sample_t      pending [$];
    rate_result_t expected_rates [$];
    sample_t      in_flight;
    logic [31:0]  gen_last = '0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           err_count = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_rate_state();
        for (int k = 0; k < hra_pkg::RATE_COUNT; k++) ring_q[k] = '0;
        wr_idx_q = '0;
        last_beat_q = '0;
        avg_q = '0;
        inst_q = '0;
    endfunction

    function automatic rate_result_t bpm_predict(sample_t s);
        rate_result_t               r;
        logic                       finger;
        logic                       ok;
        logic [31:0]                delta;
        logic [hra_pkg::SUM_W-1:0]  sum;
        finger = (s.ir >= thr_q);
        ok = 1'b0;
        if (!finger) begin
            clear_rate_state();
        end else if (s.pulse) begin
            delta = s.stamp - last_beat_q;
            last_beat_q = s.stamp;
            inst_q = (delta == 0) ? hra_pkg::MS_PER_MINUTE
                                  : 16'(32'(hra_pkg::MS_PER_MINUTE) / delta);
            if ((64'(hra_pkg::MS_PER_MINUTE) > 64'(min_q) * 64'(delta)) &&
                (64'(hra_pkg::MS_PER_MINUTE) < 64'(max_q) * 64'(delta))) begin
                ok = 1'b1;
                ring_q[wr_idx_q] = inst_q[7:0];
                wr_idx_q = wr_idx_q + hra_pkg::IDX_W'(1);
                sum = '0;
                for (int k = 0; k < hra_pkg::RATE_COUNT; k++)
                    sum = sum + hra_pkg::SUM_W'(ring_q[k]);
                avg_q = 8'(sum / hra_pkg::RATE_COUNT);
            end
        end
        r.finger   = finger;
        r.accepted = ok;
        r.inst     = inst_q;
        r.avg      = avg_q;
        r.elev     = finger && (avg_q >= elev_q);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: %s got %0d want %0d", $time, what, got, want);
        err_count++;
    endtask

    // input side: drives queued samples and queues one expected result per accepted item
    always @(posedge clk or negedge rst_n) begin : send_proc
        logic took;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            took = in_valid && in_ready;
            if (took) expected_rates.push_back(bpm_predict(in_flight));
            if (!in_valid || took) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                    !(pending[0].drain && expected_rates.size() != 0)) begin
                    in_flight = pending.pop_front();
                    in_valid <= 1'b1;
                    ir_level <= in_flight.ir;
                    beat     <= in_flight.pulse;
                    time_ms  <= in_flight.stamp;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : result_proc
        rate_result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_rates.size() == 0) begin
                    flag_mismatch("result with nothing pending", 0, 0);
                end else begin
                    want = expected_rates.pop_front();
                    if (finger_present !== want.finger)
                        flag_mismatch("finger_present", finger_present, want.finger);
                    if (beat_accepted !== want.accepted)
                        flag_mismatch("beat_accepted", beat_accepted, want.accepted);
                    if (instant_rate !== want.inst)
                        flag_mismatch("instant_rate", instant_rate, want.inst);
                    if (average_rate !== want.avg)
                        flag_mismatch("average_rate", average_rate, want.avg);
                    if (rate_elevated !== want.elev)
                        flag_mismatch("rate_elevated", rate_elevated, want.elev);
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("heart_rate_averager_top: mismatch");
        $finish;
    end

    task automatic cfg_write(input logic [hra_pkg::CIDX_W-1:0] idx,
                             input logic [hra_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            hra_pkg::CFG_FINGER_THR: thr_q  = val[17:0];
            hra_pkg::CFG_MIN_RATE:   min_q  = val[7:0];
            hra_pkg::CFG_MAX_RATE:   max_q  = val[7:0];
            hra_pkg::CFG_ELEV_RATE:  elev_q = val[7:0];
            default: ;
        endcase
    endtask

    // upper bits of the narrow registers carry junk; only the low byte counts
    function automatic logic [hra_pkg::CFG_W-1:0] byte_reg(input logic [7:0] v);
        return {10'($urandom), v};
    endfunction

    task automatic queue_sample(input logic [17:0] ir, input logic pulse,
                                input logic [31:0] stamp, input logic drain);
        sample_t s;
        s.ir = ir;
        s.pulse = pulse;
        s.stamp = stamp;
        s.drain = drain;
        pending.push_back(s);
    endtask

    // mostly a finger on the sensor with plausible beat trains, some finger
    // loss, bursts of odd intervals and counter wrap
    task automatic queue_random(input int n);
        sample_t     s;
        int unsigned pick;
        int unsigned d;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            s.drain = ($urandom_range(49) == 0);
            if (pick < 8 && thr_q != 0) begin
                s.ir = (pick < 2) ? thr_q - 18'd1 : 18'($urandom_range(thr_q - 1));
                s.pulse = $urandom_range(1);
                s.stamp = $urandom;
                gen_last = '0;
            end else begin
                s.ir = (pick < 12) ? thr_q : 18'(thr_q + $urandom_range(IR_MAX - thr_q));
                s.pulse = ($urandom_range(2) == 0);
                if (s.pulse) begin
                    pick = $urandom_range(99);
                    if (pick < 40)      d = $urandom_range(900, 235);
                    else if (pick < 65) d = $urandom_range(3000, 900);
                    else if (pick < 77) d = $urandom_range(240);
                    else if (pick < 87) d = $urandom_range(70000, 3000);
                    else                d = $urandom;
                    s.stamp = gen_last + d;
                    gen_last = s.stamp;
                end else begin
                    s.stamp = gen_last + $urandom_range(400);
                end
            end
            pending.push_back(s);
        end
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || in_valid || expected_rates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int send_mode [6];
        int recv_mode [6];
        send_mode = '{0, 61, 0, 34, 61, 0};
        recv_mode = '{0, 0, 61, 34, 0, 61};
        thr_q  = hra_pkg::FINGER_THR_RST;
        min_q  = hra_pkg::MIN_RATE_RST;
        max_q  = hra_pkg::MAX_RATE_RST;
        elev_q = hra_pkg::ELEV_RATE_RST;
        clear_rate_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = send_mode[ph];
            stall_pct = recv_mode[ph];
            case (ph)
                0: begin
                    // reset settings; beat intervals hit both range edges
                    queue_sample(18'd0,     1'b1, 32'hFFFF_FFFF, 1'b0);
                    queue_sample(18'd49999, 1'b1, 32'd1234,      1'b0);
                    queue_sample(18'd50000, 1'b1, 32'd0,         1'b0);
                    queue_sample(IR_MAX,    1'b1, 32'd500,       1'b0);
                    queue_sample(18'd60000, 1'b1, 32'd1000,      1'b0);
                    queue_sample(18'd70000, 1'b1, 32'd1500,      1'b0);
                    queue_sample(18'd80000, 1'b1, 32'd2000,      1'b0);
                    queue_sample(18'd90000, 1'b0, 32'd2100,      1'b0);
                    queue_sample(18'd100000, 1'b1, 32'd5000,     1'b0);
                    queue_sample(18'd100000, 1'b1, 32'd5235,     1'b0);
                    queue_sample(18'd100000, 1'b1, 32'd5471,     1'b0);
                    queue_sample(18'd120000, 1'b1, 32'hFFFF_FE00, 1'b0);
                    queue_sample(18'd120000, 1'b1, 32'h0000_0090, 1'b0);
                    queue_sample(18'd120000, 1'b1, 32'h0000_0091, 1'b0);
                    queue_sample(18'd0,      1'b0, 32'h0000_1000, 1'b1);
                    queue_sample(18'd150000, 1'b1, 32'd700,       1'b0);
                    queue_sample(18'd150000, 1'b0, 32'hAAAA_5555, 1'b0);
                    queue_sample(IR_MAX,     1'b1, 32'd1200,      1'b1);
                    gen_last = 32'd1200;
                end
                1: begin
                    cfg_write(hra_pkg::CFG_FINGER_THR, 18'd0);
                    cfg_write(hra_pkg::CFG_MIN_RATE,   byte_reg(8'd0));
                    cfg_write(hra_pkg::CFG_MAX_RATE,   byte_reg(8'd255));
                    cfg_write(hra_pkg::CFG_ELEV_RATE,  byte_reg(8'd0));
                end
                2: begin
                    cfg_write(hra_pkg::CFG_FINGER_THR, IR_MAX);
                    cfg_write(hra_pkg::CFG_MIN_RATE,   byte_reg(8'd255));
                    cfg_write(hra_pkg::CFG_MAX_RATE,   byte_reg(8'd255));
                    cfg_write(hra_pkg::CFG_ELEV_RATE,  byte_reg(8'd255));
                end
                3: begin
                    cfg_write(hra_pkg::CFG_FINGER_THR, 18'($urandom_range(200000, 1000)));
                    cfg_write(hra_pkg::CFG_MIN_RATE,   byte_reg(8'd40));
                    cfg_write(hra_pkg::CFG_MAX_RATE,   byte_reg(8'd180));
                    cfg_write(hra_pkg::CFG_ELEV_RATE,  byte_reg(8'd90));
                end
                4: begin
                    // max rate of zero shuts every beat out
                    cfg_write(hra_pkg::CFG_FINGER_THR, 18'd50000);
                    cfg_write(hra_pkg::CFG_MIN_RATE,   byte_reg(8'd20));
                    cfg_write(hra_pkg::CFG_MAX_RATE,   byte_reg(8'd0));
                    cfg_write(hra_pkg::CFG_ELEV_RATE,  byte_reg(8'd1));
                end
                default: begin
                    cfg_write(hra_pkg::CFG_FINGER_THR, 18'd30000);
                    cfg_write(hra_pkg::CFG_MIN_RATE,   byte_reg(8'd30));
                    cfg_write(hra_pkg::CFG_MAX_RATE,   byte_reg(8'd220));
                    cfg_write(hra_pkg::CFG_ELEV_RATE,  byte_reg(8'd70));
                end
            endcase
            queue_random(150);
            wait_drained();
        end

        if (err_count == 0 && expected_rates.size() == 0) begin
            $display("heart_rate_averager_top: match");
        end else begin
            $display("heart_rate_averager_top: mismatch");
        end
        $finish;
    end
endmodule
